/* rtl/gmc_pkg.sv */
// Shared types and constants of the grid move checker.
// Depends on nothing; the checker unit and the testbench use it by scoped names.
package gmc_pkg;

  // Fixed field and register widths.
  localparam int COORD_W = 6;
  localparam int CFG_W   = 7;
  localparam int DIM_W   = 9;   // holds a clamped dimension up to 256
  localparam int IDX_W   = 16;  // holds col * rows + row for any legal size

  localparam logic [CFG_W-1:0] DIM_RESET = 7'd64;

  // Configuration register indexes.
  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_ROWS    = 1'b1;

  typedef enum logic [2:0] {
    STATUS_DONE    = 3'd0,
    STATUS_EMPTY   = 3'd1,
    STATUS_BENT    = 3'd2,
    STATUS_BLOCKED = 3'd3,
    STATUS_RANGE   = 3'd4
  } status_e;

  // Zero acts as one, anything above the maximum acts as the maximum.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] value,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] wide;
    wide = DIM_W'(value);
    if (value == '0) begin
      return DIM_W'(1);
    end else if (wide > maxv) begin
      return maxv;
    end
    return wide;
  endfunction

endpackage

/* rtl/grid_move_checker_unit.sv */
// Grid move checker: one-bit occupancy map in a RAM, cell writes and checked moves.
// Sequence: a write or a range fault passes the address, eval and finish states; a move
// also reads its origin and walks its path one cell per cycle (up to MAX_COLUMNS-1
// along a row, MAX_ROWS-1 along a column); a clear path then takes ST_CLRORG, ST_SETDST.
// Throughput: one item at a time, taken only in the idle state; the RAM has one read port.
// Reset: clears control state, then zeroes every RAM cell (MAX_COLUMNS*MAX_ROWS, 4096 by
// default) with in_ready_o low; configuration writes are taken during the sweep.
module grid_move_checker_unit #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration write port
  input  logic                        cfg_we_i,
  input  logic                        cfg_addr_i,
  input  logic [gmc_pkg::CFG_W-1:0]   cfg_wdata_i,
  // input items
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        action_i,
  input  logic [gmc_pkg::COORD_W-1:0] origin_col_i,
  input  logic [gmc_pkg::COORD_W-1:0] origin_row_i,
  input  logic [gmc_pkg::COORD_W-1:0] dest_col_i,
  input  logic [gmc_pkg::COORD_W-1:0] dest_row_i,
  input  logic                        cell_value_i,
  // results
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [2:0]                  status_o
);

  localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam logic [gmc_pkg::DIM_W-1:0] MAX_COLS_DIM = gmc_pkg::DIM_W'(MAX_COLUMNS);
  localparam logic [gmc_pkg::DIM_W-1:0] MAX_ROWS_DIM = gmc_pkg::DIM_W'(MAX_ROWS);
  localparam logic [ADDR_W-1:0]         LAST_ADDR    = ADDR_W'(DEPTH - 1);
  localparam logic [gmc_pkg::COORD_W-1:0] COORD_ONE  = gmc_pkg::COORD_W'(1);

  // Sequencer states.
  localparam logic [3:0] ST_CLEAR  = 4'd0;  // zero the RAM after reset
  localparam logic [3:0] ST_IDLE   = 4'd1;  // wait for an item
  localparam logic [3:0] ST_ADDR   = 4'd2;  // range check, origin address, path geometry
  localparam logic [3:0] ST_EVAL   = 4'd3;  // cell write, or issue the origin read
  localparam logic [3:0] ST_ORIG   = 4'd4;  // origin data back, start the path walk
  localparam logic [3:0] ST_WALK   = 4'd5;  // one path cell per cycle
  localparam logic [3:0] ST_CLRORG = 4'd6;  // accepted move: clear the origin
  localparam logic [3:0] ST_SETDST = 4'd7;  // accepted move: set the destination
  localparam logic [3:0] ST_FINISH = 4'd8;  // hand the status to the output register

  logic [3:0] state_q, state_d;

  // Configuration registers.
  logic [gmc_pkg::CFG_W-1:0] cols_cfg_q, rows_cfg_q;

  // Latched item.
  logic                        action_q, value_q;
  logic [gmc_pkg::COORD_W-1:0] oc_q, orow_q, dc_q, dr_q;

  // Per-item working registers.
  logic                        range_bad_q;
  logic                        straight_q;
  logic                        dir_neg_q;
  logic [gmc_pkg::COORD_W-1:0] rem_q, rem_d;
  logic [ADDR_W-1:0]           org_addr_q;
  logic [ADDR_W-1:0]           stride_q;
  logic [ADDR_W-1:0]           walk_q, walk_d;
  logic [ADDR_W-1:0]           clr_q;
  gmc_pkg::status_e            status_q, status_d;

  // Output register.
  logic                        out_valid_q;
  gmc_pkg::status_e            out_status_q;

  // RAM ports.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [0:0]        ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [0:0]        ram_rdata;

  // Address-stage arithmetic.
  logic [gmc_pkg::DIM_W-1:0]   cols_eff, rows_eff;
  logic                        bad_now;
  logic                        along_row, along_col;
  logic [gmc_pkg::IDX_W-1:0]   org_idx;
  logic [gmc_pkg::COORD_W-1:0] steps_now;
  logic                        neg_now;
  logic [ADDR_W-1:0]           stride_now;

  // Walk address: step off the origin on the first path cell, off the last cell after.
  logic [ADDR_W-1:0] walk_base, walk_next;

  logic in_xfer, finish_go;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign finish_go  = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);

  // ------------------------------------------------------------------
  // Configuration: plain writes, taken in any state.
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_cfg_q <= gmc_pkg::DIM_RESET;
      rows_cfg_q <= gmc_pkg::DIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        gmc_pkg::REG_COLUMNS: cols_cfg_q <= cfg_wdata_i;
        gmc_pkg::REG_ROWS:    rows_cfg_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Address stage. Cell (col, row) lives at col * rows + row, so a step
  // along a row moves the address by rows and a step along a column by one.
  // ------------------------------------------------------------------
  always_comb begin
    cols_eff  = gmc_pkg::clamp_dim(cols_cfg_q, MAX_COLS_DIM);
    rows_eff  = gmc_pkg::clamp_dim(rows_cfg_q, MAX_ROWS_DIM);

    // Origin always checked; destination only matters for a move.
    bad_now = (gmc_pkg::DIM_W'(oc_q) >= cols_eff) || (gmc_pkg::DIM_W'(orow_q) >= rows_eff);
    if (action_q) begin
      bad_now = bad_now || (gmc_pkg::DIM_W'(dc_q) >= cols_eff) ||
                (gmc_pkg::DIM_W'(dr_q) >= rows_eff);
    end

    org_idx = gmc_pkg::IDX_W'(oc_q) * gmc_pkg::IDX_W'(rows_eff) + gmc_pkg::IDX_W'(orow_q);

    along_row = (orow_q == dr_q);
    along_col = (oc_q == dc_q);

    if (along_row) begin
      neg_now    = (dc_q < oc_q);
      steps_now  = neg_now ? (oc_q - dc_q) : (dc_q - oc_q);
      stride_now = ADDR_W'(rows_eff);
    end else begin
      neg_now    = (dr_q < orow_q);
      steps_now  = neg_now ? (orow_q - dr_q) : (dr_q - orow_q);
      stride_now = ADDR_W'(1);
    end
  end

  assign walk_base = (state_q == ST_ORIG) ? org_addr_q : walk_q;
  assign walk_next = dir_neg_q ? (walk_base - stride_q) : (walk_base + stride_q);

  // ------------------------------------------------------------------
  // RAM access. No read whose data is used shares a cycle with a write,
  // and every write lands before the next used read is issued, so no
  // forwarding is needed.
  // ------------------------------------------------------------------
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = org_addr_q;
    ram_wdata = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
      end
      ST_EVAL: begin
        ram_we    = !range_bad_q && !action_q;
        ram_wdata = value_q;
      end
      ST_CLRORG: begin
        ram_we = 1'b1;
      end
      ST_SETDST: begin
        ram_we    = 1'b1;
        ram_waddr = walk_q;
        ram_wdata = 1'b1;
      end
      default: ;
    endcase
  end

  // Origin read from the eval state; otherwise always prefetch the next path cell.
  assign ram_raddr = (state_q == ST_EVAL) ? org_addr_q : walk_next;

  gmc_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_occ_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ------------------------------------------------------------------
  // Sequencer.
  // ------------------------------------------------------------------
  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    walk_d   = walk_q;
    rem_d    = rem_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_ADDR;
        end
      end
      ST_ADDR: begin
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (range_bad_q) begin
          status_d = gmc_pkg::STATUS_RANGE;
          state_d  = ST_FINISH;
        end else if (!action_q) begin
          status_d = gmc_pkg::STATUS_DONE;
          state_d  = ST_FINISH;
        end else begin
          state_d = ST_ORIG;
        end
      end
      ST_ORIG: begin
        if (!ram_rdata[0]) begin
          status_d = gmc_pkg::STATUS_EMPTY;
          state_d  = ST_FINISH;
        end else if (!straight_q) begin
          status_d = gmc_pkg::STATUS_BENT;
          state_d  = ST_FINISH;
        end else if (rem_q == '0) begin
          // Same origin and destination: accepted, map unchanged.
          status_d = gmc_pkg::STATUS_DONE;
          state_d  = ST_FINISH;
        end else begin
          walk_d  = walk_next;
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (ram_rdata[0]) begin
          status_d = gmc_pkg::STATUS_BLOCKED;
          state_d  = ST_FINISH;
        end else if (rem_q == COORD_ONE) begin
          // walk_q now holds the destination address.
          state_d = ST_CLRORG;
        end else begin
          walk_d = walk_next;
          rem_d  = rem_q - COORD_ONE;
        end
      end
      ST_CLRORG: begin
        state_d = ST_SETDST;
      end
      ST_SETDST: begin
        status_d = gmc_pkg::STATUS_DONE;
        state_d  = ST_FINISH;
      end
      ST_FINISH: begin
        if (finish_go) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + ADDR_W'(1);
      end
    end
  end

  // Item payload and working registers: no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      action_q <= action_i;
      value_q  <= cell_value_i;
      oc_q     <= origin_col_i;
      orow_q   <= origin_row_i;
      dc_q     <= dest_col_i;
      dr_q     <= dest_row_i;
    end
    if (state_q == ST_ADDR) begin
      range_bad_q <= bad_now;
      straight_q  <= along_row || along_col;
      dir_neg_q   <= neg_now;
      stride_q    <= stride_now;
      org_addr_q  <= ADDR_W'(org_idx);
      rem_q       <= steps_now;
    end else begin
      rem_q <= rem_d;
    end
    walk_q   <= walk_d;
    status_q <= status_d;
  end

  // ------------------------------------------------------------------
  // Output register: hold the status until its transfer completes.
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish_go) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish_go) begin
      out_status_q <= status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;

  // ------------------------------------------------------------------
  // Assertions.
  // ------------------------------------------------------------------
  a_no_reclear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(state_q) != ST_CLEAR) |-> (state_q != ST_CLEAR))
    else $error("clear sweep re-entered after it finished");

  a_xfer_starts_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == ST_ADDR))
    else $error("input transfer did not start address stage");

  a_walk_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (rem_q != '0) && straight_q)
    else $error("path walk with no remaining cells or bent path");

  a_set_after_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SETDST) |-> ($past(state_q) == ST_CLRORG))
    else $error("destination set without clearing the origin");

  a_ram_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_CLEAR) || (state_q == ST_EVAL) ||
               (state_q == ST_CLRORG) || (state_q == ST_SETDST))
    else $error("occupancy write outside a write state");

endmodule

/* rtl/gmc_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; contents are undefined until written.
module gmc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* tb/grid_move_checker_unit_tb.sv */
// Self-checking testbench for grid_move_checker_unit: cell writes and checked moves.
// Depends on gmc_pkg (status codes, register indexes, widths) and the unit itself.
`timescale 1ns / 100ps

module grid_move_checker_unit_tb;

  localparam int MAX_COLUMNS     = 64;
  localparam int MAX_ROWS        = 64;
  localparam int CELLS           = MAX_COLUMNS * MAX_ROWS;
  localparam int IDLE_PCT        = 22;     // idle cycles per hundred on each side
  localparam int WATCHDOG_LIMIT  = 20000;  // covers the clearing sweep after reset
  localparam int DRAIN_GUARD     = 100;    // longer than the longest move latency
  localparam int RANDOM_PHASES   = 14;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int STEADY_PHASE    = 7;      // phase run with no idling on either side

  // Item operations.
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_MOVE  = 1'b1;

  // Occupancy map slots: the live map follows accepted transfers, the plan map
  // follows queued items so the generator can pick occupied origins.
  localparam int LIVE_MAP = 0;
  localparam int PLAN_MAP = 1;

  typedef struct packed {
    logic                        action;
    logic [gmc_pkg::COORD_W-1:0] origin_col;
    logic [gmc_pkg::COORD_W-1:0] origin_row;
    logic [gmc_pkg::COORD_W-1:0] dest_col;
    logic [gmc_pkg::COORD_W-1:0] dest_row;
    logic                        cell_value;
  } grid_item_t;

  // DUT inputs: known from time zero.
  logic                        clk_i        = 1'b0;
  logic                        rst_ni       = 1'b0;
  logic                        cfg_we_i     = 1'b0;
  logic                        cfg_addr_i   = gmc_pkg::REG_COLUMNS;
  logic [gmc_pkg::CFG_W-1:0]   cfg_wdata_i  = '0;
  logic                        in_valid_i   = 1'b0;
  logic                        action_i     = ACT_WRITE;
  logic [gmc_pkg::COORD_W-1:0] origin_col_i = '0;
  logic [gmc_pkg::COORD_W-1:0] origin_row_i = '0;
  logic [gmc_pkg::COORD_W-1:0] dest_col_i   = '0;
  logic [gmc_pkg::COORD_W-1:0] dest_row_i   = '0;
  logic                        cell_value_i = 1'b0;
  logic                        out_ready_i  = 1'b0;
  logic                        in_ready_o;
  logic                        out_valid_o;
  logic [2:0]                  status_o;

  // Predictor state: the register copies and two occupancy maps.
  logic [gmc_pkg::CFG_W-1:0] grid_cols_reg = gmc_pkg::DIM_RESET;
  logic [gmc_pkg::CFG_W-1:0] grid_rows_reg = gmc_pkg::DIM_RESET;
  bit                        occ [2][CELLS];

  grid_item_t        pending_items[$];
  grid_item_t        item_on_bus;
  gmc_pkg::status_e  expected_status_q[$];
  int unsigned       mismatch_count = 0;
  int unsigned       stall_cycles   = 0;
  bit                steady_flow    = 1'b0;

  grid_move_checker_unit #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .origin_col_i (origin_col_i),
    .origin_row_i (origin_row_i),
    .dest_col_i   (dest_col_i),
    .dest_row_i   (dest_row_i),
    .cell_value_i (cell_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o)
  );

  always #5 clk_i = ~clk_i;

  // A register of zero acts as one; anything above the maximum acts as the maximum.
  function automatic int used_dim(input logic [gmc_pkg::CFG_W-1:0] value, input int maxv);
    if (value == '0) begin
      return 1;
    end
    return (int'(value) > maxv) ? maxv : int'(value);
  endfunction

  // Cells are laid out column-major with the row count as stride.
  function automatic int cell_at(input int col, input int row, input int rows);
    int idx;
    idx = col * rows + row;
    return (idx < CELLS) ? idx : 0;
  endfunction

  // Work out the status of one item and apply its effect to map slot m.
  function automatic gmc_pkg::status_e settle_item(input int m, input grid_item_t item);
    int cols, rows, c, r;
    cols = used_dim(grid_cols_reg, MAX_COLUMNS);
    rows = used_dim(grid_rows_reg, MAX_ROWS);
    // Range comes first, for writes and moves alike.
    if (item.origin_col >= cols || item.origin_row >= rows) begin
      return gmc_pkg::STATUS_RANGE;
    end
    if (item.action == ACT_WRITE) begin
      occ[m][cell_at(item.origin_col, item.origin_row, rows)] = item.cell_value;
      return gmc_pkg::STATUS_DONE;
    end
    if (item.dest_col >= cols || item.dest_row >= rows) begin
      return gmc_pkg::STATUS_RANGE;
    end
    if (!occ[m][cell_at(item.origin_col, item.origin_row, rows)]) begin
      return gmc_pkg::STATUS_EMPTY;
    end
    if (item.origin_row != item.dest_row && item.origin_col != item.dest_col) begin
      return gmc_pkg::STATUS_BENT;
    end
    // Walk from the cell after the origin up to the destination, inclusive.
    c = item.origin_col;
    r = item.origin_row;
    while (c != item.dest_col || r != item.dest_row) begin
      if (item.origin_row == item.dest_row) begin
        c = (item.dest_col > item.origin_col) ? c + 1 : c - 1;
      end else begin
        r = (item.dest_row > item.origin_row) ? r + 1 : r - 1;
      end
      if (occ[m][cell_at(c, r, rows)]) begin
        return gmc_pkg::STATUS_BLOCKED;
      end
    end
    // Clear the origin first so a move onto itself leaves the cell occupied.
    occ[m][cell_at(item.origin_col, item.origin_row, rows)] = 1'b0;
    occ[m][cell_at(item.dest_col, item.dest_row, rows)] = 1'b1;
    return gmc_pkg::STATUS_DONE;
  endfunction

  // Mostly a short hop from the given coordinate, sometimes anywhere in the span.
  function automatic logic [gmc_pkg::COORD_W-1:0] near_coord(input int from, input int span);
    int to;
    if ($urandom_range(99) < 60) begin
      to = from + int'($urandom_range(6)) - 3;
    end else begin
      to = $urandom_range(span - 1);
    end
    if (to < 0) begin
      to = 0;
    end else if (to > span - 1) begin
      to = span - 1;
    end
    return gmc_pkg::COORD_W'(to);
  endfunction

  task automatic queue_item(input grid_item_t item);
    void'(settle_item(PLAN_MAP, item));
    pending_items.push_back(item);
  endtask

  task automatic queue_fields(input logic act, input int oc, input int orow,
                              input int dc, input int dr, input logic val);
    grid_item_t item;
    item.action     = act;
    item.origin_col = gmc_pkg::COORD_W'(oc);
    item.origin_row = gmc_pkg::COORD_W'(orow);
    item.dest_col   = gmc_pkg::COORD_W'(dc);
    item.dest_row   = gmc_pkg::COORD_W'(dr);
    item.cell_value = val;
    queue_item(item);
  endtask

  // Noise in a fifth of the items, in-grid writes in a quarter, and moves from
  // occupied origins, mostly straight and short, in the rest.
  task automatic plan_random_item();
    grid_item_t item;
    int cols, rows, pick, tries;
    cols = used_dim(grid_cols_reg, MAX_COLUMNS);
    rows = used_dim(grid_rows_reg, MAX_ROWS);
    pick = $urandom_range(99);
    item.action     = logic'($urandom_range(1));
    item.origin_col = gmc_pkg::COORD_W'($urandom);
    item.origin_row = gmc_pkg::COORD_W'($urandom);
    item.dest_col   = gmc_pkg::COORD_W'($urandom);
    item.dest_row   = gmc_pkg::COORD_W'($urandom);
    item.cell_value = logic'($urandom_range(1));
    if (pick >= 20) begin
      item.origin_col = gmc_pkg::COORD_W'($urandom_range(cols - 1));
      item.origin_row = gmc_pkg::COORD_W'($urandom_range(rows - 1));
      item.dest_col   = gmc_pkg::COORD_W'($urandom_range(cols - 1));
      item.dest_row   = gmc_pkg::COORD_W'($urandom_range(rows - 1));
    end
    if (pick >= 20 && pick < 45) begin
      item.action     = ACT_WRITE;
      item.cell_value = ($urandom_range(99) < 45);
    end else if (pick >= 45) begin
      item.action = ACT_MOVE;
      for (tries = 0; tries < 16 &&
           !occ[PLAN_MAP][cell_at(item.origin_col, item.origin_row, rows)]; tries++) begin
        item.origin_col = gmc_pkg::COORD_W'($urandom_range(cols - 1));
        item.origin_row = gmc_pkg::COORD_W'($urandom_range(rows - 1));
      end
      if (!occ[PLAN_MAP][cell_at(item.origin_col, item.origin_row, rows)]) begin
        // Sparse map: fill the cell instead, so later moves find occupants.
        item.action     = ACT_WRITE;
        item.cell_value = 1'b1;
      end else if ($urandom_range(9) < 8) begin
        if ($urandom_range(1) == 1) begin
          item.dest_row = item.origin_row;
          item.dest_col = near_coord(item.origin_col, cols);
        end else begin
          item.dest_col = item.origin_col;
          item.dest_row = near_coord(item.origin_row, rows);
        end
      end
    end
    queue_item(item);
  endtask

  // Start planning from the live map as it stands once the block is idle.
  task automatic start_plan();
    for (int i = 0; i < CELLS; i++) begin
      occ[PLAN_MAP][i] = occ[LIVE_MAP][i];
    end
  endtask

  // Wait until every queued item is transferred and every status has come back.
  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid_i || expected_status_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic write_reg(input logic reg_idx, input int value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= reg_idx;
    cfg_wdata_i <= gmc_pkg::CFG_W'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (reg_idx == gmc_pkg::REG_COLUMNS) begin
      grid_cols_reg = gmc_pkg::CFG_W'(value);
    end else begin
      grid_rows_reg = gmc_pkg::CFG_W'(value);
    end
  endtask

  // Driver: on a transfer, predict its status; then present the next pending
  // item or drop valid. Payload is held until the transfer.
  always @(posedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_ready_o)) begin
      if (in_valid_i) begin
        expected_status_q.push_back(settle_item(LIVE_MAP, item_on_bus));
      end
      if (pending_items.size() != 0 && (steady_flow || $urandom_range(99) >= IDLE_PCT)) begin
        item_on_bus   = pending_items.pop_front();
        action_i     <= item_on_bus.action;
        origin_col_i <= item_on_bus.origin_col;
        origin_row_i <= item_on_bus.origin_row;
        dest_col_i   <= item_on_bus.dest_col;
        dest_row_i   <= item_on_bus.dest_row;
        cell_value_i <= item_on_bus.cell_value;
        in_valid_i   <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: compare each result transfer with the oldest prediction, and
  // stall the result side at random.
  always @(posedge clk_i) begin
    gmc_pkg::status_e want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_status_q.size() == 0) begin
          $error("status: expected none, actual %0d", status_o);
          mismatch_count++;
        end else begin
          want = expected_status_q.pop_front();
          if (status_o !== want) begin
            $error("status: expected %0d, actual %0d", want, status_o);
            mismatch_count++;
          end
        end
      end
      out_ready_i <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog: end the run when no transfer happens on either side for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int phase, n, cols_set, rows_set;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed items on the full 64 by 64 grid left by reset.
    start_plan();
    queue_fields(ACT_WRITE,  0,  0,  0,  0, 1'b1);  // corner cells
    queue_fields(ACT_WRITE, 63, 63,  0,  0, 1'b1);
    queue_fields(ACT_WRITE, 63,  0,  0,  0, 1'b1);
    queue_fields(ACT_MOVE,   0,  0,  0,  0, 1'b0);  // move onto itself
    queue_fields(ACT_MOVE,   1,  1,  1,  2, 1'b0);  // empty origin
    queue_fields(ACT_MOVE,   0,  0,  5,  5, 1'b0);  // diagonal
    queue_fields(ACT_MOVE,   0,  0, 63,  0, 1'b0);  // destination taken
    queue_fields(ACT_MOVE,   0,  0, 62,  0, 1'b0);  // long row path
    queue_fields(ACT_MOVE,  62,  0, 62, 63, 1'b0);  // full column path
    queue_fields(ACT_MOVE,  62, 63,  0, 63, 1'b0);  // row path going down
    queue_fields(ACT_MOVE,  63, 63, 63,  0, 1'b0);  // column path going down, blocked
    queue_fields(ACT_WRITE,  0, 63, 63, 63, 1'b0);  // clear; destination ignored
    queue_fields(ACT_MOVE,   0, 63,  0,  0, 1'b0);  // from the cleared cell
    queue_fields(ACT_WRITE, 42, 21, 21, 42, 1'b1);  // alternating bit patterns
    queue_fields(ACT_MOVE,  42, 21, 42, 22, 1'b1);  // value ignored by a move
    wait_drained();

    // Directed items on a 5 by 3 grid: coordinates outside it and on its edges.
    write_reg(gmc_pkg::REG_COLUMNS, 5);
    write_reg(gmc_pkg::REG_ROWS, 3);
    start_plan();
    queue_fields(ACT_WRITE,  5,  0,  0,  0, 1'b1);
    queue_fields(ACT_WRITE,  0,  3,  0,  0, 1'b1);
    queue_fields(ACT_WRITE,  4,  2,  0,  0, 1'b1);
    queue_fields(ACT_MOVE,   4,  2,  5,  2, 1'b0);
    queue_fields(ACT_MOVE,   4,  2,  4,  3, 1'b0);
    queue_fields(ACT_MOVE,   7,  1,  1,  1, 1'b0);
    queue_fields(ACT_MOVE,   4,  2,  0,  2, 1'b0);
    queue_fields(ACT_MOVE,  63, 63,  0,  0, 1'b0);
    wait_drained();

    // Random phases: grid extremes first, then small grids where moves succeed often.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin cols_set = 0;   rows_set = 0;   end
        1: begin cols_set = 1;   rows_set = 64;  end
        2: begin cols_set = 64;  rows_set = 1;   end
        3: begin cols_set = 127; rows_set = 127; end
        4: begin cols_set = 64;  rows_set = 64;  end
        5: begin cols_set = 100; rows_set = 2;   end
        default: begin
          cols_set = $urandom_range(2, 12);
          rows_set = $urandom_range(2, 12);
        end
      endcase
      write_reg(gmc_pkg::REG_COLUMNS, cols_set);
      write_reg(gmc_pkg::REG_ROWS, rows_set);
      steady_flow = (phase == STEADY_PHASE);
      start_plan();
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        plan_random_item();
      end
      wait_drained();
    end

    // Hold a while to catch any result with no prediction behind it.
    repeat (DRAIN_GUARD) @(posedge clk_i);
    if (mismatch_count == 0 && expected_status_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/gmc_pkg.sv
rtl/gmc_ram.sv
rtl/grid_move_checker_unit.sv
tb/grid_move_checker_unit_tb.sv
